// ----- hw/rtl/aes256_pkg.sv -----
// Package: AES-256 constants, S-box tables and GF(2^8) helpers.
`default_nettype none
package aes256_pkg;

  localparam int unsigned RoundKeyWords = 60;
  localparam int unsigned KeyWords      = 8;
  localparam int unsigned Rounds        = 14;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 64;

  localparam logic [CfgIdxWidth-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_IV_HI = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_IV_LO = 3'd5;

  localparam logic [7:0] GfPoly = 8'h1B;

  typedef logic [127:0] block_t;
  typedef logic [31:0]  word_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[a];
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GfPoly) : {a[6:0], 1'b0};
  endfunction

  // InvMixColumns on one column: 0E,0B,0D,09 coefficients
  function automatic word_t inv_mix_col(input word_t c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // round constant for expansion step n (1..7)
  function automatic logic [7:0] rcon(input logic [2:0] n);
    logic [7:0] r;
    case (n)
      3'd1: r = 8'h01;
      3'd2: r = 8'h02;
      3'd3: r = 8'h04;
      3'd4: r = 8'h08;
      3'd5: r = 8'h10;
      3'd6: r = 8'h20;
      3'd7: r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes256_if.sv -----
// Interfaces: ciphertext input channel and plaintext output channel.
`default_nettype none
interface aes256_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] ciphertext_hi;
  logic [63:0] ciphertext_lo;
  logic        message_start;
  modport source (output valid, ciphertext_hi, ciphertext_lo, message_start, input ready);
  modport sink (input valid, ciphertext_hi, ciphertext_lo, message_start, output ready);
endinterface

interface aes256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plaintext_hi;
  logic [63:0] plaintext_lo;
  modport source (output valid, plaintext_hi, plaintext_lo, input ready);
  modport sink (input valid, plaintext_hi, plaintext_lo, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aes256_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module aes256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aes256_keyexp.sv -----
// Key expansion sequencer: one schedule word per cycle into the round key RAM.
`default_nettype none
module aes256_keyexp #(
  parameter int unsigned RkWords = 60
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [255:0]               key,
  output      logic                       busy,
  output      logic                       we,
  output      logic [$clog2(RkWords)-1:0] waddr,
  output      logic [31:0]                wdata
);
  import aes256_pkg::*;

  localparam int unsigned AW = $clog2(RkWords);

  // last eight words, newest at index 7
  logic [31:0]   win [8];
  logic [AW-1:0] cnt;
  logic [31:0]   t;
  logic [31:0]   nw;

  always_comb begin
    t = win[7];
    if (cnt[2:0] == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon(cnt[5:3]), 24'h0};
    end else if (cnt[2:0] == 3'd4) begin
      t = sub_word(t);
    end
    nw = (cnt < AW'(KeyWords)) ? key[255-32*cnt[2:0] -: 32] : (win[0] ^ t);
  end

  assign we    = busy;
  assign waddr = cnt;
  assign wdata = nw;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == AW'(RkWords - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      for (int i = 0; i < 7; i++) win[i] <= win[i+1];
      win[7] <= nw;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aes256_round.sv -----
// Shared inverse round unit: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
`default_nettype none
module aes256_round (
  input  wire aes256_pkg::block_t state_in,
  input  wire aes256_pkg::block_t rkey,
  input  wire logic               first,
  input  wire logic               last,
  output      aes256_pkg::block_t state_out
);
  import aes256_pkg::*;

  block_t ss;
  block_t ak;

  // byte r+4c lives at bits 127-8*(r+4c)
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ss[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(state_in[127-8*(r+4*c) -: 8]);
      end
    end
    ak = (first ? state_in : ss) ^ rkey;
    if (first || last) begin
      state_out = ak;
    end else begin
      for (int c = 0; c < 4; c++) begin
        state_out[127-32*c -: 32] = inv_mix_col(ak[127-32*c -: 32]);
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aes256_cbc_decrypt_block.sv -----
// Top level: AES-256 CBC decryption with iterative round unit and round key RAM.
`default_nettype none
// One ciphertext item is taken, then in_ch.ready stays low while the item is
// worked. A single round unit is used 15 times (initial key addition, 13 full
// inverse rounds and the final round). Each pass first fetches its four 32-bit
// round key words through the registered read of the round key RAM and then
// runs the round. After reset or any key register write the first item is
// preceded by a 60-word key expansion, which keeps ready low from the cycle the
// item is presented until the expansion is done. The plaintext sits in an
// output register; ready returns the cycle after it has been taken.
module aes256_cbc_decrypt_block #(
  parameter int unsigned ROUND_KEY_WORDS = aes256_pkg::RoundKeyWords
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  aes256_in_if.sink                                 in_ch,
  aes256_out_if.source                              out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [aes256_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [aes256_pkg::CfgDataWidth-1:0]  cfg_data
);
  import aes256_pkg::*;

  localparam int unsigned AW = $clog2(ROUND_KEY_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEXP  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]   st;
  logic [63:0]  key_r [4];
  logic [127:0] iv;
  logic         key_stale;
  logic [127:0] chain;
  logic [127:0] ct;
  block_t       state;
  block_t       rk;
  block_t       rnd_out;
  logic [3:0]   rnd;      // round number, 14 down to 0
  logic [2:0]   wsel;     // word fetch step
  logic [127:0] result;

  logic          kx_busy, kx_we, kx_start;
  logic [AW-1:0] kx_waddr;
  logic [31:0]   kx_wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_stale <= 1'b1;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_0: begin key_r[0] <= cfg_data; key_stale <= 1'b1; end
          REG_KEY_1: begin key_r[1] <= cfg_data; key_stale <= 1'b1; end
          REG_KEY_2: begin key_r[2] <= cfg_data; key_stale <= 1'b1; end
          REG_KEY_3: begin key_r[3] <= cfg_data; key_stale <= 1'b1; end
          REG_IV_HI: iv[127:64] <= cfg_data;
          REG_IV_LO: iv[63:0]   <= cfg_data;
          default: ;
        endcase
      end
      if (kx_start) begin
        key_stale <= 1'b0;
      end
    end
  end

  assign kx_start = (st == S_IDLE) && in_ch.valid && key_stale;

  aes256_keyexp #(.RkWords(ROUND_KEY_WORDS)) u_keyexp (
    .clk   (clk),
    .rst   (rst),
    .start (kx_start),
    .key   ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .busy  (kx_busy),
    .we    (kx_we),
    .waddr (kx_waddr),
    .wdata (kx_wdata)
  );

  // round key word address: 4*rnd + wsel[1:0]
  assign raddr = AW'({rnd, 2'b00}) + AW'(wsel[1:0]);

  aes256_ram #(.Width(32), .Depth(ROUND_KEY_WORDS)) u_rk_ram (
    .clk   (clk),
    .we    (kx_we),
    .waddr (kx_waddr),
    .wdata (kx_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  aes256_round u_round (
    .state_in  (state),
    .rkey      (rk),
    .first     (rnd == 4'(Rounds)),
    .last      (rnd == 4'd0),
    .state_out (rnd_out)
  );

  assign in_ch.ready    = (st == S_IDLE) && !key_stale;
  assign out_ch.valid   = (st == S_OUT);
  assign out_ch.plaintext_hi = result[127:64];
  assign out_ch.plaintext_lo = result[63:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      rnd   <= '0;
      wsel  <= '0;
      chain <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (kx_start) begin
            st <= S_KEXP;
          end else if (in_ch.valid && in_ch.ready) begin
            st   <= S_FETCH;
            rnd  <= 4'(Rounds);
            wsel <= '0;
            if (in_ch.message_start) chain <= iv;
          end
        end
        S_KEXP: begin
          if (!kx_busy && !kx_start) st <= S_IDLE;
        end
        S_FETCH: begin
          // read issued for word wsel; data for wsel-1 arrives now
          wsel <= wsel + 1'b1;
          if (wsel == 3'd4) begin
            st <= S_ROUND;
          end
        end
        S_ROUND: begin
          wsel <= '0;
          if (rnd == 4'd0) begin
            st    <= S_OUT;
            chain <= ct;
          end else begin
            rnd <= rnd - 1'b1;
            st  <= S_FETCH;
          end
        end
        S_OUT: begin
          if (out_ch.ready) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (st == S_IDLE && in_ch.valid && in_ch.ready) begin
      ct    <= {in_ch.ciphertext_hi, in_ch.ciphertext_lo};
      state <= {in_ch.ciphertext_hi, in_ch.ciphertext_lo};
    end
    if (st == S_FETCH && wsel != 3'd0) begin
      rk <= {rk[95:0], rdata};
    end
    if (st == S_ROUND) begin
      state <= rnd_out;
      if (rnd == 4'd0) begin
        result <= rnd_out ^ chain;
      end
    end
  end
endmodule
`default_nettype wire
